FILE: hw/rtl/cau_pkg.sv
package cau_pkg;

    // Width of one operand or result part.
    localparam int WORD_W = 32;

    // Quotient bits produced by the divider, one per stage.
    localparam int QUOT_W = 33;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Depth of the result buffer, which also bounds the words in flight.
    localparam int OUTQ_DEPTH = 64;

    // Request codes as they arrive on req_type.
    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_SUB    = 3'd1,
        REQ_MUL    = 3'd2,
        REQ_DIV    = 3'd3,
        REQ_SCALE  = 3'd4,
        REQ_INC    = 3'd5,
        REQ_DEC    = 3'd6,
        REQ_UNUSED = 3'd7
    } req_t;

    // Classes of work that the back carries out.
    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,
        CLS_SUM   = 3'd1,
        CLS_MUL   = 3'd2,
        CLS_DIV   = 3'd3,
        CLS_SCALE = 3'd4
    } cls_t;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Classified request word held in the queue.
    typedef struct packed {
        cls_t        cls;
        logic [31:0] a_re;
        logic [31:0] a_im;
        logic [31:0] b_re;
        logic [31:0] b_im;
        logic [32:0] d_re;
        logic [32:0] d_im;
    } cmd_t;

    // Result word.
    typedef struct packed {
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic [1:0]  status;
    } res_t;

    // One saturated result part and its saturation flag.
    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } part_t;

    // Turns a sign and magnitude into a saturated 32-bit two's complement part.
    function automatic part_t sat_part(input logic neg, input logic [63:0] mag);
        part_t p;
        p.sat = 1'b0;
        p.val = '0;
        if (!neg) begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                p.sat = 1'b1;
                p.val = 32'h7FFF_FFFF;
            end else begin
                p.val = mag[31:0];
            end
        end else begin
            if (mag > 64'h0000_0000_8000_0000) begin
                p.sat = 1'b1;
                p.val = 32'h8000_0000;
            end else begin
                p.val = 32'd0 - mag[31:0];
            end
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/cau_front.sv
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic          push,
    input  logic          q_full,
    input  logic [2:0]    req_type,
    input  logic [31:0]   a_re,
    input  logic [31:0]   a_im,
    input  logic [31:0]   b_re,
    input  logic [31:0]   b_im,
    output logic          full,
    output logic          q_wr,
    output cau_pkg::cmd_t cmd
);
    import cau_pkg::*;

    localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

    logic signed [32:0] b_re_x;
    logic signed [32:0] b_im_x;

    // A word is taken whenever the queue has room.
    assign full = q_full;
    assign q_wr = push && !q_full;

    assign b_re_x = 33'($signed(b_re));
    assign b_im_x = 33'($signed(b_im));

    // Classify the request and work out the addend of the additive forms.
    always_comb
    begin
        cmd.a_re = a_re;
        cmd.a_im = a_im;
        cmd.b_re = b_re;
        cmd.b_im = b_im;
        cmd.d_re = '0;
        cmd.d_im = '0;
        case (req_t'(req_type))
            REQ_ADD:
            begin
                cmd.cls  = CLS_SUM;
                cmd.d_re = b_re_x;
                cmd.d_im = b_im_x;
            end
            REQ_SUB:
            begin
                cmd.cls  = CLS_SUM;
                cmd.d_re = -b_re_x;
                cmd.d_im = -b_im_x;
            end
            REQ_INC:
            begin
                cmd.cls  = CLS_SUM;
                cmd.d_re = ONE;
                cmd.d_im = ONE;
            end
            REQ_DEC:
            begin
                cmd.cls  = CLS_SUM;
                cmd.d_re = -ONE;
                cmd.d_im = -ONE;
            end
            REQ_MUL:   cmd.cls = CLS_MUL;
            REQ_DIV:   cmd.cls = CLS_DIV;
            REQ_SCALE: cmd.cls = CLS_SCALE;
            default:   cmd.cls = CLS_NONE;
        endcase
    end

endmodule

FILE: hw/rtl/cau_queue.sv
module cau_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  cau_pkg::cmd_t din,
    input  logic          rd,
    output logic          q_full,
    output logic          q_empty,
    output cau_pkg::cmd_t dout
);
    import cau_pkg::*;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign q_full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign dout    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(wr) - CNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_rd_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> !q_empty)
        else $error("queue read while empty");

endmodule

FILE: hw/rtl/cau_back.sv
module cau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  cau_pkg::cmd_t q_data,
    output logic          q_rd,
    input  logic          out_pop,
    output logic          res_valid,
    output cau_pkg::res_t res
);
    import cau_pkg::*;

    localparam int          CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int          SHIFT = QUOT_W - FRAC_BITS;
    localparam logic [63:0] RND   = (64'd1 << FRAC_BITS) - 64'd1;

    typedef struct packed {
        cls_t             cls;
        logic             dz;
        logic [63:0]      den;
        logic [1:0]       neg;
        logic [1:0]       ovf;
        logic [1:0][63:0] mag;
        logic [1:0][64:0] rem;
        logic [1:0][32:0] quo;
    } div_stage_t;

    // Credit count: words issued and not yet popped at the output.
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic               s1_valid_reg;
    cls_t               s1_cls_reg;
    logic signed [31:0] s1_a_reg [2];
    logic signed [32:0] s1_d_reg [2];
    logic signed [63:0] s1_p00_reg;
    logic signed [63:0] s1_p11_reg;
    logic signed [63:0] s1_p10_reg;
    logic signed [63:0] s1_p01_reg;
    logic signed [63:0] s1_sq0_reg;
    logic signed [63:0] s1_sq1_reg;

    logic               s2_valid_reg;
    cls_t               s2_cls_reg;
    logic [1:0]         s2_neg_reg;
    logic [63:0]        s2_mag_reg [2];
    logic [63:0]        s2_den_reg;
    logic signed [65:0] sum [2];

    div_stage_t s3_next;
    div_stage_t st_reg [0:QUOT_W];
    logic       vld_reg [0:QUOT_W];

    div_stage_t  fin;
    logic [63:0] fin_mag [2];
    part_t       part [2];
    res_t        res_next;
    res_t        res_reg;
    logic        res_valid_reg;

    // Issue from the queue only while the result buffer has a place reserved.
    assign q_rd     = !q_empty && (cnt_reg < CNT_W'(OUTQ_DEPTH));
    assign cnt_next = cnt_reg + CNT_W'(q_rd) - CNT_W'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Stage one: the partial products, each in its own multiplier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cls_reg  <= q_data.cls;
        s1_a_reg[0] <= $signed(q_data.a_re);
        s1_a_reg[1] <= $signed(q_data.a_im);
        s1_d_reg[0] <= $signed(q_data.d_re);
        s1_d_reg[1] <= $signed(q_data.d_im);
        s1_p00_reg  <= $signed(q_data.a_re) * $signed(q_data.b_re);
        s1_p11_reg  <= $signed(q_data.a_im) * $signed(q_data.b_im);
        s1_p10_reg  <= $signed(q_data.a_im) * $signed(q_data.b_re);
        s1_p01_reg  <= $signed(q_data.a_re) * $signed(q_data.b_im);
        s1_sq0_reg  <= $signed(q_data.b_re) * $signed(q_data.b_re);
        s1_sq1_reg  <= $signed(q_data.b_im) * $signed(q_data.b_im);
    end

    // Stage two: exact sums, split into sign and magnitude.
    always_comb
    begin
        case (s1_cls_reg)
            CLS_SUM:
            begin
                sum[0] = 66'(s1_a_reg[0]) + 66'(s1_d_reg[0]);
                sum[1] = 66'(s1_a_reg[1]) + 66'(s1_d_reg[1]);
            end
            CLS_MUL:
            begin
                sum[0] = 66'(s1_p00_reg) - 66'(s1_p11_reg);
                sum[1] = 66'(s1_p10_reg) + 66'(s1_p01_reg);
            end
            CLS_DIV:
            begin
                sum[0] = 66'(s1_p00_reg) + 66'(s1_p11_reg);
                sum[1] = 66'(s1_p10_reg) - 66'(s1_p01_reg);
            end
            CLS_SCALE:
            begin
                sum[0] = 66'(s1_p00_reg);
                sum[1] = 66'(s1_p10_reg);
            end
            default:
            begin
                sum[0] = '0;
                sum[1] = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cls_reg    <= s1_cls_reg;
        s2_neg_reg[0] <= sum[0][65];
        s2_neg_reg[1] <= sum[1][65];
        s2_mag_reg[0] <= sum[0][65] ? 64'(-sum[0]) : sum[0][63:0];
        s2_mag_reg[1] <= sum[1][65] ? 64'(-sum[1]) : sum[1][63:0];
        s2_den_reg    <= 64'(s1_sq0_reg) + 64'(s1_sq1_reg);
    end

    // Stage three: floor shift of the products, or the divider's starting remainder
    // and the check for a quotient that cannot fit.
    always_comb
    begin
        s3_next.cls = s2_cls_reg;
        s3_next.dz  = (s2_den_reg == '0);
        s3_next.den = s2_den_reg;
        s3_next.neg = s2_neg_reg;
        s3_next.quo = '0;
        for (int k = 0; k < 2; k++)
        begin
            s3_next.rem[k] = 65'(s2_mag_reg[k] >> SHIFT);
            s3_next.ovf[k] = (s2_mag_reg[k] >> SHIFT) >= s2_den_reg;
            if (s2_cls_reg == CLS_MUL || s2_cls_reg == CLS_SCALE)
            begin
                s3_next.mag[k] = s2_neg_reg[k] ? ((s2_mag_reg[k] + RND) >> FRAC_BITS)
                                               : (s2_mag_reg[k] >> FRAC_BITS);
            end
            else
            begin
                s3_next.mag[k] = s2_mag_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= s3_next;
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        localparam int BIT = QUOT_W - 1 - j;

        div_stage_t nxt;
        logic [1:0] nbit;
        logic [64:0] trial [2];

        // Next dividend bit: the magnitude shifted up by the fraction width.
        if (BIT >= FRAC_BITS)
        begin : g_bit
            assign nbit[0] = st_reg[j].mag[0][BIT-FRAC_BITS];
            assign nbit[1] = st_reg[j].mag[1][BIT-FRAC_BITS];
        end
        else
        begin : g_zero
            assign nbit = '0;
        end

        always_comb
        begin
            nxt = st_reg[j];
            for (int k = 0; k < 2; k++)
            begin
                trial[k] = {st_reg[j].rem[k][63:0], nbit[k]};
                if (trial[k] >= {1'b0, st_reg[j].den})
                begin
                    nxt.rem[k] = trial[k] - {1'b0, st_reg[j].den};
                    nxt.quo[k] = {st_reg[j].quo[k][31:0], 1'b1};
                end
                else
                begin
                    nxt.rem[k] = trial[k];
                    nxt.quo[k] = {st_reg[j].quo[k][31:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[j+1] <= nxt;
        end
    end

    // Final stage: pick the magnitude, saturate and set the status.
    assign fin = st_reg[QUOT_W];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (fin.cls == CLS_DIV)
            begin
                fin_mag[k] = fin.ovf[k] ? '1 : 64'(fin.quo[k]);
            end
            else
            begin
                fin_mag[k] = fin.mag[k];
            end
            part[k] = sat_part(fin.neg[k], fin_mag[k]);
        end
        if (fin.cls == CLS_DIV && fin.dz)
        begin
            res_next.res_re = '0;
            res_next.res_im = '0;
            res_next.status = ST_DIV_ZERO;
        end
        else
        begin
            res_next.res_re = part[0].val;
            res_next.res_im = part[1].val;
            res_next.status = (part[0].sat || part[1].sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= vld_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(OUTQ_DEPTH))
        else $error("more words in flight than the result buffer holds");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_DIV_ZERO)
            |-> (res_reg.res_re == '0 && res_reg.res_im == '0))
        else $error("divide by zero with non-zero result parts");

endmodule

FILE: hw/rtl/cau_outq.sv
module cau_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  cau_pkg::res_t din,
    input  logic          pop,
    output logic          empty,
    output cau_pkg::res_t dout
);
    import cau_pkg::*;

    localparam int ADDR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W  = $clog2(OUTQ_DEPTH + 1);

    res_t              mem [OUTQ_DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              head_valid_reg;
    logic              head_valid_next;
    res_t              head_reg;
    logic              pop_acc;
    logic              load;

    // The head register holds the oldest word; the memory holds the rest.
    assign pop_acc = pop && head_valid_reg;
    assign load    = (cnt_reg != '0) && (!head_valid_reg || pop_acc);
    assign empty   = !head_valid_reg;
    assign dout    = head_reg;

    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(wr) - CNT_W'(load);
        if (load)
        begin
            head_valid_next = 1'b1;
        end
        else if (pop_acc)
        begin
            head_valid_next = 1'b0;
        end
        else
        begin
            head_valid_next = head_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (load)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg        <= cnt_next;
            head_valid_reg <= head_valid_next;
        end
    end

    // Memory write and registered read into the head.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= din;
        end
        if (load)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg + CNT_W'(head_valid_reg)) <= CNT_W'(OUTQ_DEPTH))
        else $error("result buffer overflow");

endmodule

FILE: hw/rtl/complex_arithmetic_unit_core.sv
// Complex-number arithmetic on signed Q15.16 parts (FRAC_BITS fractional bits).
// Each word pushed carries two operands and an operation, and gives exactly one
// result word, in order. Multiply and scale round toward minus infinity, divide
// truncates toward zero, and any part that overflows saturates with status 2;
// dividing by zero gives zero parts and status 1. The unit takes one word per
// cycle for as long as results are popped. Each word goes through a four-word
// queue, then a pipeline of product, sum and set-up stages followed by a
// 33-stage restoring divider that yields one quotient bit per stage. Up to 68
// words may be in flight or waiting: four in the input queue and 64 beyond it.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  req_type,
    input  logic [31:0] a_re,
    input  logic [31:0] a_im,
    input  logic [31:0] b_re,
    input  logic [31:0] b_im,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] res_re,
    output logic [31:0] res_im,
    output logic [1:0]  status
);
    import cau_pkg::*;

    cmd_t cmd;
    cmd_t q_data;
    res_t res;
    res_t head;
    logic q_full;
    logic q_empty;
    logic q_wr;
    logic q_rd;
    logic res_valid;
    logic out_pop;

    assign out_pop = pop && !empty;

    // Front: accepts and classifies words.
    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .push     (push),
        .q_full   (q_full),
        .req_type (req_type),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .full     (full),
        .q_wr     (q_wr),
        .cmd      (cmd)
    );

    // Short queue between front and back.
    cau_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .din     (cmd),
        .rd      (q_rd),
        .q_full  (q_full),
        .q_empty (q_empty),
        .dout    (q_data)
    );

    // Back: arithmetic pipeline.
    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_rd      (q_rd),
        .out_pop   (out_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result buffer.
    cau_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .din   (res),
        .pop   (pop),
        .empty (empty),
        .dout  (head)
    );

    assign res_re = head.res_re;
    assign res_im = head.res_im;
    assign status = head.status;

endmodule

FILE: test/cau_checker.sv
// Watches both queue sides of the complex arithmetic unit, predicts every
// result word from the accepted request words and compares them in order.
module cau_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  req_type,
    input  logic [31:0] a_re,
    input  logic [31:0] a_im,
    input  logic [31:0] b_re,
    input  logic [31:0] b_im,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] res_re,
    input  logic [31:0] res_im,
    input  logic [1:0]  status,
    output int          errors,
    output int          pending,
    output int          checked
);
    import cau_pkg::*;

    res_t expected_words[$];

    // Clips an exact value to a 32-bit part and notes any saturation.
    function automatic logic [31:0] clip_part(input logic signed [127:0] v,
                                              inout logic sat);
        if (v > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Exact complex arithmetic on wide signed values, then rounding and clipping.
    function automatic res_t complex_result(input logic [2:0] op,
                                            input logic [31:0] ar_bits,
                                            input logic [31:0] ai_bits,
                                            input logic [31:0] br_bits,
                                            input logic [31:0] bi_bits);
        logic signed [127:0] ar, ai, br, bi, one, xr, xi, den, nr, ni;
        logic [127:0] mr, mi;
        logic sat;
        res_t r;
        ar = $signed(ar_bits);
        ai = $signed(ai_bits);
        br = $signed(br_bits);
        bi = $signed(bi_bits);
        one = 128'sd1 <<< FRAC_BITS;
        xr = '0;
        xi = '0;
        sat = 1'b0;
        r.status = ST_OK;
        case (req_t'(op))
            REQ_ADD:
            begin
                xr = ar + br;
                xi = ai + bi;
            end
            REQ_SUB:
            begin
                xr = ar - br;
                xi = ai - bi;
            end
            REQ_INC:
            begin
                xr = ar + one;
                xi = ai + one;
            end
            REQ_DEC:
            begin
                xr = ar - one;
                xi = ai - one;
            end
            REQ_MUL:
            begin
                xr = (ar * br - ai * bi) >>> FRAC_BITS;
                xi = (ai * br + ar * bi) >>> FRAC_BITS;
            end
            REQ_SCALE:
            begin
                xr = (ar * br) >>> FRAC_BITS;
                xi = (ai * br) >>> FRAC_BITS;
            end
            REQ_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.status = ST_DIV_ZERO;
                end
                else
                begin
                    // Conjugate product over the squared magnitude, truncated.
                    nr = ar * br + ai * bi;
                    ni = ai * br - ar * bi;
                    mr = ((nr < 0) ? -nr : nr) << FRAC_BITS;
                    mi = ((ni < 0) ? -ni : ni) << FRAC_BITS;
                    mr = mr / den;
                    mi = mi / den;
                    xr = (nr < 0) ? -$signed(mr) : $signed(mr);
                    xi = (ni < 0) ? -$signed(mi) : $signed(mi);
                end
            end
            default:
            begin
            end
        endcase
        r.res_re = clip_part(xr, sat);
        r.res_im = clip_part(xi, sat);
        if (sat && r.status == ST_OK)
            r.status = ST_SAT;
        return r;
    endfunction

    // Queue a prediction per accepted request and compare each popped word.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (push && !full)
                expected_words.push_back(complex_result(req_type, a_re, a_im, b_re, b_im));
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word re=%h im=%h status=%0d",
                             $time, res_re, res_im, status);
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked++;
                    if (res_re !== want.res_re)
                    begin
                        errors++;
                        $display("%0t: res_re expected %h actual %h", $time, want.res_re, res_re);
                    end
                    if (res_im !== want.res_im)
                    begin
                        errors++;
                        $display("%0t: res_im expected %h actual %h", $time, want.res_im, res_im);
                    end
                    if (status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

FILE: test/tb_top.sv
// Drives request words into the complex arithmetic unit and pops its results
// with random idle bursts on both sides; the checker does the comparison.
module tb_top;
    import cau_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  req_type;
    logic [31:0] a_re, a_im, b_re, b_im;
    logic        empty;
    logic        pop;
    logic [31:0] res_re, res_im;
    logic [1:0]  status;
    logic        full_seen;
    logic        calm;
    int          errors, pending, checked;
    int          pop_idle;

    complex_arithmetic_unit_core dut (.*);

    cau_checker checker_i (.*);

    // Clock with a period of 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Full only moves at a rising edge, so its value at the falling edge is
    // the value seen by the next rising edge.
    always @(negedge clk)
        full_seen <= full;

    // Result side: pop with random idle bursts, steady once the run is calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_idle <= 0;
        end
        else if (pop_idle > 0)
        begin
            pop <= 1'b0;
            pop_idle <= pop_idle - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            pop <= 1'b0;
            pop_idle <= $urandom_range(0, 6);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Offers one word and waits for the edge that accepts it.
    task automatic send_word(input req_t op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        push <= 1'b1;
        req_type <= op;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        @(posedge clk);
        while (full_seen)
            @(posedge clk);
    endtask

    // Random idle burst on the request side.
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Operand part: mostly modest values, some full range, some extremes.
    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom();
            default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        calm = 1'b0;
        req_type = REQ_ADD;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: extremes, every operation, divide by zero, unused code.
        send_word(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(REQ_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0);
        send_word(REQ_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(REQ_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
        send_word(REQ_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(REQ_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000);
        send_word(REQ_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_word(REQ_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send_word(REQ_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
        send_word(REQ_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
        send_word(REQ_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(REQ_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(REQ_SCALE, 32'h0003_0000, 32'hFFFF_8000, 32'h0000_8000, 32'h1234_5678);
        send_word(REQ_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_word(REQ_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0);
        send_word(REQ_INC, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(REQ_DEC, 32'h8000_0000, 32'h0001_0000, 32'hAAAA_AAAA, 32'h5555_5555);
        send_word(REQ_UNUSED, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'h0);

        // Hold back until every result so far has come out.
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Random words; the last part runs without any idling.
        for (int i = 0; i < 750; i++)
        begin
            if (i == 650)
                calm = 1'b1;
            send_word(req_t'($urandom_range(0, 7)), rand_part(), rand_part(),
                      ($urandom_range(0, 15) == 0) ? 32'h0 : rand_part(),
                      ($urandom_range(0, 15) == 0) ? 32'h0 : rand_part());
            maybe_idle();
        end
        push <= 1'b0;

        // Drain, then allow for the pipeline latency.
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Summary: %0d result words checked over all seven operations,", checked);
        $display("the unused code, divide by zero and saturation, with idling on both sides.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
